@@ hw/rtl/set_assoc_cache_tag_lru_fifo_top_assert.svh @@
// assertion macros used by the checker file
`ifndef SET_ASSOC_CACHE_TAG_LRU_FIFO_TOP_ASSERT_SVH
`define SET_ASSOC_CACHE_TAG_LRU_FIFO_TOP_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define SATAG_ASSERT_SAME(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("satag check failed");

// consequent checked in the cycle after the antecedent
`define SATAG_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("satag check failed");

`endif

@@ hw/rtl/satag_pkg.sv @@
`default_nettype none

package satag_pkg;

    // fixed field widths of the channels
    localparam int ADDR_W    = 32;
    localparam int MODE_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int WAY_OUT_W = 2;
    localparam int COUNT_W   = 32;

    // access modes
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_INVAL = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_HIT   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISS  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_INVAL = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NONE  = 2'd3;

    // replacement policy register values
    localparam logic POLICY_LRU  = 1'b0;
    localparam logic POLICY_FIFO = 1'b1;

    typedef logic [COUNT_W-1:0] count_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIVIDE,
        ST_READ,
        ST_LOOKUP
    } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/satag_req_if.sv @@
`default_nettype none

interface satag_req_if;
    import satag_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] address;

    modport source (output valid, mode, address, input ready);
    modport sink   (input valid, mode, address, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/satag_rsp_if.sv @@
`default_nettype none

interface satag_rsp_if;
    import satag_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [WAY_OUT_W-1:0] way;
    count_t               access_count;
    count_t               read_access_count;
    count_t               write_access_count;
    count_t               miss_count;
    count_t               read_miss_count;
    count_t               write_miss_count;

    modport source (
        output valid, status, way, access_count, read_access_count, write_access_count,
               miss_count, read_miss_count, write_miss_count,
        input  ready
    );
    modport sink (
        input  valid, status, way, access_count, read_access_count, write_access_count,
               miss_count, read_miss_count, write_miss_count,
        output ready
    );
endinterface

`default_nettype wire

@@ hw/rtl/set_assoc_cache_tag_lru_fifo_top.sv @@
// With SETS a power of two the set row is read as the request is taken and the result is
// registered from the lookup state; otherwise a multiply by the reciprocal of SETS first runs
// the product, quotient and remainder steps, then a separate read state. A new request is
// taken only once the last one has written back its set row; a held result stalls the lookup.
// Reset: counters and policy clear at once; a clearing pass then writes every set row
// empty, one row a cycle, before the first request is taken.
`default_nettype none

module set_assoc_cache_tag_lru_fifo_top #(
    parameter int WAYS        = 4,
    parameter int SETS        = 256,
    parameter int OFFSET_BITS = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    satag_req_if.sink   req,
    satag_rsp_if.source rsp
);
    import satag_pkg::*;

    localparam int LINE_W  = ADDR_W - OFFSET_BITS;
    localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int FLOG    = $clog2(SETS + 1) - 1;
    localparam bit IS_POW2 = (SETS == (1 << FLOG));
    localparam int TAG_W   = LINE_W - FLOG;
    localparam int IDX_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int AGE_W   = IDX_W;
    localparam int CNT_W   = 2;
    localparam int SHIFT_Q = (SET_W > 1) ? SET_W - 1 : 0;

    localparam logic [AGE_W-1:0] AGE_MAX   = AGE_W'(WAYS - 1);
    localparam logic [SET_W-1:0] SET_LAST  = SET_W'(SETS - 1);
    localparam logic [CNT_W-1:0] STEP_MUL  = 2'd0;
    localparam logic [CNT_W-1:0] STEP_QUOT = 2'd1;
    localparam logic [CNT_W-1:0] STEP_LAST = 2'd2;

    // multiplier for the line number that gives line / SETS
    localparam logic [LINE_W-1:0] RECIP = LINE_W'(((64'd1 << LINE_W) *
        ((64'd1 << SET_W) - 64'(SETS))) / 64'(SETS) + 64'd1);

    typedef struct packed {
        logic             occ;
        logic [AGE_W-1:0] age;
        logic [TAG_W-1:0] tag;
    } entry_t;

    typedef entry_t [WAYS-1:0] row_t;

    // tag memory, one row per set
    row_t mem [SETS];

    state_t              state_reg, state_next;
    logic [MODE_W-1:0]   mode_reg;
    logic [LINE_W-1:0]   line_reg;
    logic [LINE_W-1:0]   prod_hi_reg;
    logic [SET_W-1:0]    rem_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [SET_W-1:0]    set_reg;
    logic [TAG_W-1:0]    tag_reg;
    logic                policy_reg;
    row_t                rd_row_reg;
    logic                rsp_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [WAY_OUT_W-1:0] way_reg;
    count_t              access_reg, read_access_reg, write_access_reg;
    count_t              miss_reg, read_miss_reg, write_miss_reg;

    logic              accept;
    logic              commit;
    logic              rd_en, wr_en;
    logic [SET_W-1:0]  rd_addr;
    row_t              wr_data;
    logic [LINE_W-1:0] in_line;
    logic [SET_W-1:0]  in_set;
    logic [TAG_W-1:0]  in_tag;
    logic [2*LINE_W-1:0] prod_full;
    logic [LINE_W-1:0] quot_sum;
    logic [LINE_W-1:0] set_prod;

    logic [WAYS-1:0]   match_vec, empty_vec, oldest_vec;
    logic              hit_found, empty_found;
    logic [IDX_W-1:0]  hit_idx, empty_idx, old_idx, victim_idx;
    logic [AGE_W-1:0]  hit_age;
    logic              is_access;
    row_t              new_row;
    logic [STATUS_W-1:0] status_next;
    logic [IDX_W-1:0]  way_next;

    // address split
    assign in_line = req.address[ADDR_W-1:OFFSET_BITS];
    assign in_set  = SET_W'(in_line & LINE_W'(SETS - 1));
    assign in_tag  = TAG_W'(in_line >> FLOG);

    // reciprocal multiply for the set split when SETS is not a power of two
    assign prod_full = (2*LINE_W)'(line_reg) * (2*LINE_W)'(RECIP);
    assign quot_sum  = prod_hi_reg + ((line_reg - prod_hi_reg) >> 1);
    assign set_prod  = LINE_W'(tag_reg) * LINE_W'(SETS);

    assign commit    = !rsp_valid_reg || rsp.ready;
    assign is_access = (mode_reg inside {MODE_READ, MODE_WRITE});

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (set_reg == SET_LAST)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (req.valid)
                    state_next = IS_POW2 ? ST_LOOKUP : ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (cnt_reg == STEP_LAST)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_LOOKUP;
            end
            ST_LOOKUP:
            begin
                if (commit)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        req.ready = 1'b0;
        rd_en     = 1'b0;
        wr_en     = 1'b0;
        rd_addr   = in_set;
        wr_data   = new_row;
        case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_data = '0;
            end
            ST_IDLE:
            begin
                req.ready = 1'b1;
                rd_en     = req.valid && IS_POW2;
            end
            ST_READ:
            begin
                rd_en   = 1'b1;
                rd_addr = rem_reg;
            end
            ST_LOOKUP:
            begin
                wr_en = commit &&
                        (mode_reg inside {MODE_READ, MODE_WRITE, MODE_INVAL});
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    assign accept = req.valid && req.ready;

    // memory read port, registered data
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_row_reg <= mem[rd_addr];
    end

    // memory write port, clearing pass and write-back share it
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[set_reg] <= wr_data;
    end

    // way compare and victim candidates
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            match_vec[w] = rd_row_reg[w].occ && (rd_row_reg[w].tag == tag_reg);
            empty_vec[w] = !rd_row_reg[w].occ;
            oldest_vec[w] = 1'b1;
            for (int v = 0; v < WAYS; v++)
            begin
                if ((v < w) && (rd_row_reg[v].age >= rd_row_reg[w].age))
                    oldest_vec[w] = 1'b0;
                if ((v > w) && (rd_row_reg[v].age > rd_row_reg[w].age))
                    oldest_vec[w] = 1'b0;
            end
        end
    end

    // first-way priority encoders
    always_comb
    begin
        hit_found   = 1'b0;
        empty_found = 1'b0;
        hit_idx     = '0;
        empty_idx   = '0;
        old_idx     = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (match_vec[w])
            begin
                hit_found = 1'b1;
                hit_idx   = IDX_W'(w);
            end
            if (empty_vec[w])
            begin
                empty_found = 1'b1;
                empty_idx   = IDX_W'(w);
            end
            if (oldest_vec[w])
                old_idx = IDX_W'(w);
        end
    end

    assign victim_idx = empty_found ? empty_idx : old_idx;
    assign hit_age    = rd_row_reg[hit_idx].age;

    // updated set row and result
    always_comb
    begin
        new_row     = rd_row_reg;
        status_next = STATUS_NONE;
        way_next    = '0;
        case (mode_reg)
            MODE_READ, MODE_WRITE:
            begin
                if (hit_found)
                begin
                    status_next = STATUS_HIT;
                    way_next    = hit_idx;
                    if (policy_reg == POLICY_LRU)
                    begin
                        for (int w = 0; w < WAYS; w++)
                        begin
                            if ((IDX_W'(w) != hit_idx) && rd_row_reg[w].occ &&
                                (rd_row_reg[w].age < hit_age) &&
                                (rd_row_reg[w].age != AGE_MAX))
                                new_row[w].age = rd_row_reg[w].age + 1'b1;
                        end
                        new_row[hit_idx].age = '0;
                    end
                end
                else
                begin
                    status_next = STATUS_MISS;
                    way_next    = victim_idx;
                    for (int w = 0; w < WAYS; w++)
                    begin
                        if ((IDX_W'(w) != victim_idx) && rd_row_reg[w].occ &&
                            (rd_row_reg[w].age != AGE_MAX))
                            new_row[w].age = rd_row_reg[w].age + 1'b1;
                    end
                    new_row[victim_idx].occ = 1'b1;
                    new_row[victim_idx].tag = tag_reg;
                    new_row[victim_idx].age = '0;
                end
            end
            MODE_INVAL:
            begin
                if (hit_found)
                begin
                    status_next      = STATUS_INVAL;
                    way_next         = hit_idx;
                    new_row[hit_idx] = '0;
                end
            end
            default:
            begin
                status_next = STATUS_NONE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            set_reg       <= '0;
            policy_reg    <= POLICY_LRU;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
                policy_reg <= cfg_wr_data;
            if ((state_reg == ST_CLEAR) && (set_reg != SET_LAST))
                set_reg <= set_reg + 1'b1;
            else if (accept && IS_POW2)
                set_reg <= in_set;
            else if (state_reg == ST_READ)
                set_reg <= rem_reg;
            if ((state_reg == ST_LOOKUP) && commit)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // access and miss counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            access_reg       <= '0;
            read_access_reg  <= '0;
            write_access_reg <= '0;
            miss_reg         <= '0;
            read_miss_reg    <= '0;
            write_miss_reg   <= '0;
        end
        else if ((state_reg == ST_LOOKUP) && commit && is_access)
        begin
            access_reg <= access_reg + 1'b1;
            if (mode_reg == MODE_READ)
                read_access_reg <= read_access_reg + 1'b1;
            else
                write_access_reg <= write_access_reg + 1'b1;
            if (!hit_found)
            begin
                miss_reg <= miss_reg + 1'b1;
                if (mode_reg == MODE_READ)
                    read_miss_reg <= read_miss_reg + 1'b1;
                else
                    write_miss_reg <= write_miss_reg + 1'b1;
            end
        end
    end

    // request payload and set split steps: product, quotient, remainder
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= req.mode;
            line_reg <= in_line;
            rem_reg  <= '0;
            cnt_reg  <= '0;
            tag_reg  <= in_tag;
        end
        else if (state_reg == ST_DIVIDE)
        begin
            case (cnt_reg)
                STEP_MUL:
                begin
                    prod_hi_reg <= prod_full[2*LINE_W-1:LINE_W];
                end
                STEP_QUOT:
                begin
                    tag_reg <= TAG_W'(quot_sum >> SHIFT_Q);
                end
                default:
                begin
                    rem_reg <= SET_W'(line_reg - set_prod);
                end
            endcase
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_LOOKUP) && commit)
        begin
            status_reg <= status_next;
            way_reg    <= WAY_OUT_W'(way_next);
        end
    end

    assign rsp.valid              = rsp_valid_reg;
    assign rsp.status             = status_reg;
    assign rsp.way                = way_reg;
    assign rsp.access_count       = access_reg;
    assign rsp.read_access_count  = read_access_reg;
    assign rsp.write_access_count = write_access_reg;
    assign rsp.miss_count         = miss_reg;
    assign rsp.read_miss_count    = read_miss_reg;
    assign rsp.write_miss_count   = write_miss_reg;

endmodule

`default_nettype wire

@@ hw/rtl/satag_chk.sv @@
`default_nettype none

`include "set_assoc_cache_tag_lru_fifo_top_assert.svh"

module satag_chk (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           req_valid,
    input wire logic                           req_ready,
    input wire logic                           rsp_valid,
    input wire logic                           rsp_ready,
    input wire logic [satag_pkg::STATUS_W-1:0] rsp_status,
    input wire logic [satag_pkg::WAY_OUT_W-1:0] rsp_way,
    input wire satag_pkg::count_t              access_count,
    input wire satag_pkg::count_t              miss_count
);
    import satag_pkg::*;

    // a stalled result holds
    `SATAG_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_way) && $stable(miss_count))

    // one access in flight: no request transfer right after one
    `SATAG_ASSERT_NEXT(a_one_in_flight, clk, rst_n, req_valid && req_ready, !req_ready)

    // every miss is also counted as an access
    `SATAG_ASSERT_SAME(a_miss_is_access, clk, rst_n, $past(rst_n) && (miss_count != $past(miss_count)), access_count == $past(access_count) + 32'd1)

    // nothing found reports way zero
    `SATAG_ASSERT_SAME(a_none_way_zero, clk, rst_n, rsp_valid && (rsp_status == STATUS_NONE), rsp_way == 2'd0)

endmodule

bind set_assoc_cache_tag_lru_fifo_top satag_chk u_satag_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_status   (rsp.status),
    .rsp_way      (rsp.way),
    .access_count (rsp.access_count),
    .miss_count   (rsp.miss_count)
);

`default_nettype wire
